>>> sv/pmp_pkg.sv
// Shared constants, command codes and types for the protection checker.
package pmp_pkg;
	localparam int ENTRIES = 16;
	localparam int PHYS_ADDR_BITS = 56;
	localparam int WA = PHYS_ADDR_BITS - 2;
	localparam int EW = $clog2(ENTRIES);

	localparam logic [2:0] CMD_WR_ADDR = 3'd0;
	localparam logic [2:0] CMD_WR_CFG  = 3'd1;
	localparam logic [2:0] CMD_RD_ADDR = 3'd2;
	localparam logic [2:0] CMD_RD_CFG  = 3'd3;
	localparam logic [2:0] CMD_CHECK   = 3'd4;

	localparam logic [1:0] REG_ACTIVE = 2'd0;
	localparam logic [1:0] REG_GRAN   = 2'd1;
	localparam logic [1:0] REG_WIDE   = 2'd2;

	localparam logic [1:0] A_OFF   = 2'd0;
	localparam logic [1:0] A_TOR   = 2'd1;
	localparam logic [1:0] A_NA4   = 2'd2;
	localparam logic [1:0] A_NAPOT = 2'd3;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	// word-granule masks derived from the granularity register
	typedef struct packed {
		logic [WA-1:0] gm;   // ones at and above the granule
		logic [WA-1:0] lo;   // ones below the granule
	} gran_t;

	// access under check, in word units
	typedef struct packed {
		logic [WA-1:0] word;
		logic [WA-1:0] accw;
		logic [WA:0]   end_w;
	} chk_t;
endpackage

>>> sv/pmp_region_checker.sv
// Top level: command decode, entry chain, priority pick and result register.
// Each transfer is one command (address or config write/read, or an access
// check) and gives one result transfer. The command is evaluated in the cycle
// it is accepted against the entry row, whose cells pass their top-of-range
// word down the chain to serve as the next entry's TOR base; the result sits
// in an output register. A new item is taken whenever that register is empty
// or being drained, so the block sustains one item per cycle while out_stall
// is low. Config registers may be written at any time (cfg_ready is tied high)
// but must only change while the block is idle.
module pmp_region_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [3:0]  register_index,
	input  logic [63:0] write_data,
	input  logic [55:0] access_address,
	input  logic [2:0]  access_size_log2,
	input  logic [1:0]  access_kind,
	input  logic [1:0]  privilege,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] read_data,
	output logic        write_accepted,
	output logic        no_protection_trap,
	output logic        flush_request,
	output logic        matched,
	output logic [3:0]  matched_entry,
	output logic        partial_match,
	output logic        permitted
);
	import pmp_pkg::*;

	logic [4:0] active_q;
	logic [5:0] gran_q;
	logic       wide_q;

	// result register
	logic        vld_q;
	logic [63:0] rdata_q;
	logic        wacc_q, trap_q, flush_q, match_q, part_q, perm_q;
	logic [3:0]  ment_q;

	logic        accept;
	logic [4:0]  n;
	logic [5:0]  geff;
	gran_t       gran;
	chk_t        chk;
	logic [63:0] lo64;

	logic [WA-1:0] tops  [ENTRIES];
	logic [WA-1:0] addrs [ENTRIES];
	logic [7:0]    cfgs  [ENTRIES];
	logic [WA-1:0] prevs [ENTRIES];
	logic [ENTRIES-1:0] any_v, all_v, addr_we, cfg_we, lockd;
	logic [7:0]    cfg_wd [ENTRIES];

	logic [63:0] n_rdata;
	logic        n_wacc, n_trap, n_flush, n_match, n_part, n_perm, found;
	logic [3:0]  n_ment;
	logic [2:0]  s;
	logic [WA-1:0] chunks;
	logic [6:0]  koff;
	logic [7:0]  wb;
	logic [3:0]  per;
	logic        grant;

	// config port
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd16;
			gran_q   <= 6'd2;
			wide_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACTIVE: active_q <= cfg_data[4:0];
				REG_GRAN:   gran_q   <= cfg_data;
				REG_WIDE:   wide_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign n    = (active_q > 5'(ENTRIES)) ? 5'(ENTRIES) : active_q;
	assign geff = (gran_q < 6'd2) ? 6'd2 : gran_q;
	assign per  = wide_q ? 4'd8 : 4'd4;

	always_comb begin
		for (int j = 0; j < WA; j++) begin
			gran.lo[j] = (7'(j) < 7'(geff) - 7'd2);
			gran.gm[j] = ~gran.lo[j];
		end
		for (int j = 0; j < 64; j++)
			lo64[j] = (7'(j) < 7'(geff) - 7'd3) && (geff > 6'd3);
	end

	// access window in words, aligned down to its length
	always_comb begin
		s        = (access_size_log2 > 3'd6) ? 3'd6 : access_size_log2;
		chunks   = (s < 3'd2) ? WA'(1) : (WA'(1) << (s - 3'd2));
		chk.accw = ~(chunks - 1'b1);
		chk.word = access_address[55:2] & chk.accw;
		chk.end_w = {1'b0, chk.word} + {1'b0, chunks};
	end

	assign in_stall = vld_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// per-entry write enables and lock view
	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			lockd[e] = cfgs[e][7] ||
				((e + 1 < ENTRIES) && cfgs[(e + 1) % ENTRIES][7] &&
				 cfgs[(e + 1) % ENTRIES][4:3] == A_TOR && (e + 1 < ENTRIES));
			addr_we[e] = accept && command == CMD_WR_ADDR && n != 5'd0 &&
				register_index == 4'(e) && 5'(e) < n && !lockd[e];
			koff = 7'(e) - {1'b0, register_index, 2'b00};
			wb = write_data[{koff[2:0], 3'b000} +: 8] & 8'h9f;
			if (!wb[0]) wb[1] = 1'b0;
			if (geff != 6'd2 && wb[4:3] == A_NA4) wb[4:3] = A_NAPOT;
			cfg_wd[e] = wb;
			cfg_we[e] = accept && command == CMD_WR_CFG && n != 5'd0 &&
				(7'(e) >= {1'b0, register_index, 2'b00}) && koff < 7'(per) &&
				5'(e) < n && !cfgs[e][7];
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign prevs[g] = '0;
		end else begin : g_rest
			assign prevs[g] = tops[g-1];
		end
		pmp_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.addr_we(addr_we[g]), .addr_wd(write_data[WA-1:0]),
			.cfg_we(cfg_we[g]), .cfg_wd(cfg_wd[g]),
			.gran(gran), .chk(chk), .prev_top(prevs[g]),
			.top_w(tops[g]), .addr(addrs[g]), .cfg(cfgs[g]),
			.hit_any(any_v[g]), .hit_all(all_v[g])
		);
	end

	// result of the accepted command
	always_comb begin
		n_rdata = '0; n_wacc = 1'b0; n_trap = 1'b0; n_flush = 1'b0;
		n_match = 1'b0; n_part = 1'b0; n_perm = 1'b0; n_ment = '0;
		found = 1'b0; grant = 1'b0;
		if (command <= CMD_RD_CFG && n == 5'd0) begin
			n_trap = 1'b1;
		end else begin
			unique case (command)
				CMD_WR_ADDR: begin
					n_wacc  = |addr_we;
					n_flush = |addr_we;
				end
				CMD_WR_CFG: begin
					n_flush = 1'b1;
					for (int e = 0; e < ENTRIES; e++)
						if ((7'(e) >= {1'b0, register_index, 2'b00}) &&
						    (7'(e) - {1'b0, register_index, 2'b00}) < 7'(per) && 5'(e) < n)
							n_wacc = 1'b1;
				end
				CMD_RD_ADDR: begin
					if (cfgs[register_index][4:3] == A_NAPOT)
						n_rdata = {{(64-WA){1'b0}}, addrs[register_index]} | lo64;
					else
						n_rdata = {{(64-WA){1'b0}}, addrs[register_index] & gran.gm};
				end
				CMD_RD_CFG: begin
					for (int e = 0; e < ENTRIES; e++)
						if ((7'(e) >= {1'b0, register_index, 2'b00}) &&
						    (7'(e) - {1'b0, register_index, 2'b00}) < 7'(per))
							n_rdata[{3'(e - 4 * register_index), 3'b000} +: 8] = cfgs[e];
				end
				CMD_CHECK: begin
					for (int e = 0; e < ENTRIES; e++) begin
						if (!found && 5'(e) < n && any_v[e]) begin
							found   = 1'b1;
							n_match = 1'b1;
							n_ment  = 4'(e);
							n_part  = !all_v[e];
							grant = (privilege == 2'd3 && !cfgs[e][7]) ||
								(access_kind == KIND_LOAD && cfgs[e][0]) ||
								(access_kind == KIND_STORE && cfgs[e][1]) ||
								(access_kind == KIND_FETCH && cfgs[e][2]);
							n_perm  = all_v[e] && grant;
						end
					end
					if (!found) n_perm = (n == 5'd0) || (privilege == 2'd3);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= n_rdata; wacc_q <= n_wacc; trap_q <= n_trap; flush_q <= n_flush;
			match_q <= n_match; ment_q <= n_ment; part_q <= n_part; perm_q <= n_perm;
		end
	end

	assign out_valid          = vld_q;
	assign read_data          = rdata_q;
	assign write_accepted     = wacc_q;
	assign no_protection_trap = trap_q;
	assign flush_request      = flush_q;
	assign matched            = match_q;
	assign matched_entry      = ment_q;
	assign partial_match      = part_q;
	assign permitted          = perm_q;

	// an unmatched result always names entry zero
	a_ment_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !match_q |-> ment_q == 4'd0) else $error("entry without match");
	// a partial cover is never permitted
	a_part_perm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && part_q |-> !perm_q) else $error("partial match permitted");
	// entry zero, once locked, keeps its config stable
	a_lock_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfgs[0][7] |=> $stable(cfgs[0])) else $error("locked entry changed");
endmodule

>>> sv/pmp_cell.sv
// One protection entry: storage plus its match logic, chained for TOR bases.
module pmp_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  addr_we,
	input  logic [pmp_pkg::WA-1:0] addr_wd,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wd,
	input  pmp_pkg::gran_t        gran,
	input  pmp_pkg::chk_t         chk,
	input  logic [pmp_pkg::WA-1:0] prev_top,
	output logic [pmp_pkg::WA-1:0] top_w,
	output logic [pmp_pkg::WA-1:0] addr,
	output logic [7:0]            cfg,
	output logic                  hit_any,
	output logic                  hit_all
);
	import pmp_pkg::*;

	logic [WA-1:0] addr_q;
	logic [7:0]    cfg_q;
	logic [WA-1:0] m, rm, diff;
	logic [WA:0]   top_x, prev_x;
	logic [1:0]    mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cfg_q  <= '0;
		end else begin
			if (addr_we) addr_q <= addr_wd;
			if (cfg_we) cfg_q <= cfg_wd;
		end
	end

	assign addr  = addr_q;
	assign cfg   = cfg_q;
	assign mode  = cfg_q[4:3];
	assign top_w = addr_q & gran.gm;

	always_comb begin
		m       = {addr_q[WA-2:0], mode != A_NA4} | gran.lo;
		rm      = ~(m & ~(m + 1'b1));
		diff    = (chk.word ^ top_w) & rm;
		top_x   = {1'b0, top_w};
		prev_x  = {1'b0, prev_top};
		hit_any = 1'b0;
		hit_all = 1'b0;
		unique case (mode)
			A_OFF: ;
			A_TOR: begin
				hit_any = (prev_top < top_w) && (chk.word < top_w) && (chk.end_w > prev_x);
				hit_all = (prev_top <= chk.word) && (chk.end_w <= top_x);
			end
			default: begin
				hit_any = (diff & chk.accw) == '0;
				hit_all = (diff == '0) && ((rm & ~chk.accw) == '0);
			end
		endcase
	end
endmodule
